@@ rtl/csiek_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csiek_pkg
// Shared constants, codes and control types of the escape key decoder.
// ----------------------------------------------------------------------------
package csiek_pkg;

	localparam int PARAM_BUF_LEN = 16;
	localparam int CAP           = PARAM_BUF_LEN - 1;
	localparam int CNT_W         = $clog2(CAP + 1);
	localparam int IDX_W         = $clog2(CAP);
	localparam int MOD_W         = 16;

	localparam logic [MOD_W-1:0] MOD_MAX = 16'hFFFF;

	localparam logic [1:0] PHASE_IDLE    = 2'd0;
	localparam logic [1:0] PHASE_ESC     = 2'd1;
	localparam logic [1:0] PHASE_COLLECT = 2'd2;

	localparam logic [7:0] ESC_BYTE     = 8'h1B;
	localparam logic [7:0] CTRL_BS_BYTE = 8'h17;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_SEMI    = 8'h3B;
	localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHAR_UP      = 8'h41;
	localparam logic [7:0] CHAR_DOWN    = 8'h42;
	localparam logic [7:0] CHAR_RIGHT   = 8'h43;
	localparam logic [7:0] CHAR_LEFT    = 8'h44;
	localparam logic [7:0] CHAR_END     = 8'h46;
	localparam logic [7:0] CHAR_HOME    = 8'h48;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;

	localparam logic [3:0] SEMI_CODE = 4'd10;
	localparam logic [3:0] DEL_DIGIT = 4'd3;
	localparam logic [3:0] BS_DIGIT0 = 4'd1;
	localparam logic [3:0] BS_DIGIT1 = 4'd2;
	localparam logic [3:0] BS_DIGIT2 = 4'd7;

	localparam logic [3:0] KIND_PLAIN  = 4'd0;
	localparam logic [3:0] KIND_UP     = 4'd1;
	localparam logic [3:0] KIND_DOWN   = 4'd2;
	localparam logic [3:0] KIND_RIGHT  = 4'd3;
	localparam logic [3:0] KIND_LEFT   = 4'd4;
	localparam logic [3:0] KIND_WRIGHT = 4'd5;
	localparam logic [3:0] KIND_WLEFT  = 4'd6;
	localparam logic [3:0] KIND_HOME   = 4'd7;
	localparam logic [3:0] KIND_END    = 4'd8;
	localparam logic [3:0] KIND_DEL    = 4'd9;
	localparam logic [3:0] KIND_WDEL   = 4'd10;
	localparam logic [3:0] KIND_ESC    = 4'd11;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_WALK   = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic walk_start;
		logic walk_step;
		logic finish;
		logic load_out;
	} csiek_cmd_t;

	typedef struct packed {
		logic ends_seq;
		logic emit_now;
		logic walk_more;
		logic final_hit;
		logic out_free;
	} csiek_stat_t;

endpackage
`default_nettype wire

@@ rtl/csiek_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csiek_in_if
// Keyboard word channel: command bit and raw byte with valid/ready.
// ----------------------------------------------------------------------------
interface csiek_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] byte_in;

	modport source (output valid, output cmd, output byte_in, input ready);
	modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface
`default_nettype wire

@@ rtl/csiek_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csiek_out_if
// Decoded key word channel: key kind, byte and shift flag with valid/ready.
// ----------------------------------------------------------------------------
interface csiek_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_kind;
	logic [7:0] key_byte;
	logic       shift_held;

	modport source (output valid, output key_kind, output key_byte, output shift_held,
		input ready);
	modport sink   (input valid, input key_kind, input key_byte, input shift_held,
		output ready);
endinterface
`default_nettype wire

@@ rtl/csiek_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csiek_ctrl
// Sequencer: accept a word, decode it, walk the parameter buffer, emit.
// ----------------------------------------------------------------------------
module csiek_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  csiek_pkg::csiek_stat_t  st,
	output csiek_pkg::csiek_cmd_t   ctl
);

	csiek_pkg::state_t state_q;
	csiek_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			csiek_pkg::S_IDLE: begin
				ctl.accept = 1'b1;
				if (in_valid) begin
					state_d = csiek_pkg::S_DECODE;
				end
			end
			csiek_pkg::S_DECODE: begin
				ctl.decode = 1'b1;
				if (st.ends_seq) begin
					ctl.walk_start = 1'b1;
					state_d        = csiek_pkg::S_WALK;
				end else if (st.emit_now) begin
					state_d = csiek_pkg::S_EMIT;
				end else begin
					state_d = csiek_pkg::S_IDLE;
				end
			end
			csiek_pkg::S_WALK: begin
				if (st.walk_more) begin
					ctl.walk_step = 1'b1;
				end else begin
					ctl.finish = 1'b1;
					state_d    = st.final_hit ? csiek_pkg::S_EMIT : csiek_pkg::S_IDLE;
				end
			end
			csiek_pkg::S_EMIT: begin
				if (st.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = csiek_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = csiek_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csiek_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/csiek_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csiek_datapath
// Escape phase, parameter buffer, modifier accumulator and output register.
// ----------------------------------------------------------------------------
module csiek_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csiek_pkg::csiek_cmd_t  ctl,
	output csiek_pkg::csiek_stat_t st,
	input  logic                   in_valid,
	input  logic                   in_cmd,
	input  logic [7:0]             in_byte,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [3:0]             out_kind,
	output logic [7:0]             out_byte,
	output logic                   out_shift
);

	localparam int CNT_W = csiek_pkg::CNT_W;
	localparam int IDX_W = csiek_pkg::IDX_W;
	localparam int MOD_W = csiek_pkg::MOD_W;

	logic                cmd_q;
	logic [7:0]          byte_q;
	logic [1:0]          phase_q;
	logic [1:0]          phase_d;
	logic [1:0]          drains_q;
	logic [1:0]          drains_d;
	logic [1:0]          drains_inc;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [3:0]          chars_q [csiek_pkg::CAP];
	logic                store;
	logic [3:0]          code;
	logic                is_param;
	logic                emit_now;
	logic                ends_seq;
	logic [3:0]          kind_d;
	logic [7:0]          byte_d;

	logic [CNT_W-1:0]    walk_idx_q;
	logic                semi_q;
	logic                stop_q;
	logic [MOD_W-1:0]    mod_q;
	logic [3:0]          walk_char;
	logic [MOD_W+3:0]    mod_x10;
	logic [MOD_W-1:0]    mod_next;
	logic [MOD_W-1:0]    mod_m1;
	logic                mod_ge2;
	logic                ctrl_mod;
	logic                shift_mod;
	logic                del_hit;
	logic                bs_hit;
	logic                fin_hit;
	logic [3:0]          fin_kind;
	logic [7:0]          fin_byte;

	logic [3:0]          res_kind_q;
	logic [7:0]          res_byte_q;
	logic                res_shift_q;
	logic                out_valid_q;
	logic [3:0]          out_kind_q;
	logic [7:0]          out_byte_q;
	logic                out_shift_q;

	assign is_param = ((byte_q >= csiek_pkg::CHAR_ZERO) && (byte_q <= csiek_pkg::CHAR_NINE))
		|| (byte_q == csiek_pkg::CHAR_SEMI);
	assign code       = (byte_q == csiek_pkg::CHAR_SEMI) ? csiek_pkg::SEMI_CODE : byte_q[3:0];
	assign drains_inc = drains_q + 2'd1;

	always_comb begin
		phase_d  = phase_q;
		drains_d = drains_q;
		count_d  = count_q;
		store    = 1'b0;
		emit_now = 1'b0;
		ends_seq = 1'b0;
		kind_d   = csiek_pkg::KIND_PLAIN;
		byte_d   = byte_q;
		if (cmd_q) begin
			byte_d = '0;
			if (phase_q == csiek_pkg::PHASE_ESC) begin
				if (drains_inc >= 2'd2) begin
					phase_d  = csiek_pkg::PHASE_IDLE;
					drains_d = '0;
					emit_now = 1'b1;
					kind_d   = csiek_pkg::KIND_ESC;
				end else begin
					drains_d = drains_inc;
				end
			end else begin
				drains_d = '0;
			end
		end else if (phase_q == csiek_pkg::PHASE_IDLE) begin
			if (byte_q == csiek_pkg::ESC_BYTE) begin
				phase_d = csiek_pkg::PHASE_ESC;
			end else begin
				emit_now = 1'b1;
			end
		end else if (phase_q == csiek_pkg::PHASE_ESC) begin
			if (byte_q == csiek_pkg::CHAR_LBRACK) begin
				phase_d = csiek_pkg::PHASE_COLLECT;
				count_d = '0;
			end else begin
				phase_d  = csiek_pkg::PHASE_IDLE;
				emit_now = 1'b1;
			end
		end else if (is_param) begin
			if (count_q < CNT_W'(csiek_pkg::CAP)) begin
				store   = 1'b1;
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			phase_d  = csiek_pkg::PHASE_IDLE;
			ends_seq = 1'b1;
		end
	end

	assign walk_char = chars_q[walk_idx_q[IDX_W-1:0]];
	assign mod_x10   = ({4'b0, mod_q} << 3) + ({4'b0, mod_q} << 1) + {{MOD_W{1'b0}}, walk_char};
	assign mod_next  = (mod_x10 > {4'b0, csiek_pkg::MOD_MAX}) ? csiek_pkg::MOD_MAX
		: mod_x10[MOD_W-1:0];

	assign mod_m1    = mod_q - MOD_W'(1);
	assign mod_ge2   = mod_q >= MOD_W'(2);
	assign ctrl_mod  = mod_ge2 && mod_m1[2];
	assign shift_mod = mod_ge2 && mod_m1[0];
	assign del_hit   = (count_q >= CNT_W'(1)) && (chars_q[0] == csiek_pkg::DEL_DIGIT);
	assign bs_hit    = (count_q >= CNT_W'(3)) && (chars_q[0] == csiek_pkg::BS_DIGIT0)
		&& (chars_q[1] == csiek_pkg::BS_DIGIT1) && (chars_q[2] == csiek_pkg::BS_DIGIT2);

	always_comb begin
		fin_hit  = 1'b1;
		fin_kind = csiek_pkg::KIND_PLAIN;
		fin_byte = '0;
		unique case (byte_q)
			csiek_pkg::CHAR_UP:    fin_kind = csiek_pkg::KIND_UP;
			csiek_pkg::CHAR_DOWN:  fin_kind = csiek_pkg::KIND_DOWN;
			csiek_pkg::CHAR_RIGHT: begin
				fin_kind = ctrl_mod ? csiek_pkg::KIND_WRIGHT : csiek_pkg::KIND_RIGHT;
			end
			csiek_pkg::CHAR_LEFT: begin
				fin_kind = ctrl_mod ? csiek_pkg::KIND_WLEFT : csiek_pkg::KIND_LEFT;
			end
			csiek_pkg::CHAR_HOME:  fin_kind = csiek_pkg::KIND_HOME;
			csiek_pkg::CHAR_END:   fin_kind = csiek_pkg::KIND_END;
			csiek_pkg::CHAR_TILDE: begin
				if (del_hit) begin
					fin_kind = ctrl_mod ? csiek_pkg::KIND_WDEL : csiek_pkg::KIND_DEL;
				end else if (bs_hit) begin
					fin_byte = csiek_pkg::CTRL_BS_BYTE;
				end else begin
					fin_hit = 1'b0;
				end
			end
			default: fin_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && in_valid) begin
			cmd_q  <= in_cmd;
			byte_q <= in_byte;
		end
		if (ctl.decode && store) begin
			chars_q[count_q[IDX_W-1:0]] <= code;
		end
		if (ctl.walk_start) begin
			mod_q <= '0;
		end else if (ctl.walk_step && semi_q && !stop_q && (walk_char < csiek_pkg::SEMI_CODE)) begin
			mod_q <= mod_next;
		end
		if (ctl.decode && emit_now) begin
			res_kind_q  <= kind_d;
			res_byte_q  <= byte_d;
			res_shift_q <= 1'b0;
		end else if (ctl.finish) begin
			res_kind_q  <= fin_kind;
			res_byte_q  <= fin_byte;
			res_shift_q <= shift_mod;
		end
		if (ctl.load_out) begin
			out_kind_q  <= res_kind_q;
			out_byte_q  <= res_byte_q;
			out_shift_q <= res_shift_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= csiek_pkg::PHASE_IDLE;
			drains_q    <= '0;
			count_q     <= '0;
			walk_idx_q  <= '0;
			semi_q      <= 1'b0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.decode) begin
				phase_q  <= phase_d;
				drains_q <= drains_d;
				count_q  <= count_d;
			end
			if (ctl.walk_start) begin
				walk_idx_q <= '0;
				semi_q     <= 1'b0;
				stop_q     <= 1'b0;
			end else if (ctl.walk_step) begin
				walk_idx_q <= walk_idx_q + CNT_W'(1);
				if (!semi_q) begin
					if (walk_char == csiek_pkg::SEMI_CODE) begin
						semi_q <= 1'b1;
					end
				end else if (walk_char >= csiek_pkg::SEMI_CODE) begin
					stop_q <= 1'b1;
				end
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.ends_seq  = ends_seq;
	assign st.emit_now  = emit_now;
	assign st.walk_more = walk_idx_q < count_q;
	assign st.final_hit = fin_hit;
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_shift = out_shift_q;

endmodule
`default_nettype wire

@@ rtl/csi_escape_key_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csi_escape_key_decoder
// Keyboard byte decoder for xterm style escape and control sequences.
//
// kbd carries one word per keyboard byte (cmd 0) or per end of an event
// drain (cmd 1). keys carries zero or one decoded key word per kbd word.
// Both channels move a word when valid and ready are high at a clock edge.
// A kbd word is taken in the idle state, decoded in the next cycle and its
// key, if any, is loaded into the output register in the emit state once
// that register is free. A sequence final byte first walks the parameter
// buffer one character a cycle; the buffer holds at most 15 characters.
// The output register holds a finished key while the next kbd word is
// accepted; a stalled receiver holds the block in its emit state until the
// register frees. Reset returns to the idle phase with an empty buffer and no
// pending drain; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module csi_escape_key_decoder (
	input  logic         clk,
	input  logic         arst_n,
	csiek_in_if.sink     kbd,
	csiek_out_if.source  keys
);

	csiek_pkg::csiek_cmd_t  ctl;
	csiek_pkg::csiek_stat_t st;

	assign kbd.ready = ctl.accept;

	csiek_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (kbd.valid),
		.st       (st),
		.ctl      (ctl)
	);

	csiek_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.in_valid  (kbd.valid),
		.in_cmd    (kbd.cmd),
		.in_byte   (kbd.byte_in),
		.out_ready (keys.ready),
		.out_valid (keys.valid),
		.out_kind  (keys.key_kind),
		.out_byte  (keys.key_byte),
		.out_shift (keys.shift_held)
	);

endmodule
`default_nettype wire
